@@ hdl/hpb_pkg.sv @@
`default_nettype none
package hpb_pkg;

    localparam int MAX_BINS   = 64;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int NB_W       = 7;
    localparam int CNT_W      = 25;
    localparam int SUM_W      = CNT_W + 2;
    localparam int BLACK_W    = 23;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;
    localparam int COL_W      = 12;
    localparam int PROD_W     = 2 * DIM_W;

    localparam logic [7:0] FIXED_THRESHOLD = 8'd140;
    localparam logic [7:0] PIX_WHITE       = 8'd255;
    localparam logic [7:0] PIX_BLACK       = 8'd0;
    localparam logic [CNT_W-1:0]   CNT_SAT   = {CNT_W{1'b1}};
    localparam logic [BLACK_W-1:0] BLACK_SAT = {BLACK_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_BIN_COUNT    = 2'd0,
        CFG_KEEP_LARGEST = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       used_fallback;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic accept_hist;
        logic accept_out;
        logic wr_a;
        logic wr_b;
        logic sweep_start;
        logic sweep_run;
        logic pass2;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic two_bins;
        logic sweep_done;
    } t_status;

    // ceil(x / 255) for x below about 16.6k, no divider
    function automatic logic [7:0] ceil_div255(input logic [15:0] x);
        logic [15:0] y;
        logic [15:0] s;
        y = x + 16'd254;
        s = y + 16'd1 + (y >> 8);
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

@@ hdl/histogram_peak_binarizer.sv @@
// Output-pass pixel: result registered the cycle after transfer; one per cycle when
//   the output is not stalled. Histogram-pass pixel: accept, then read-modify-write
//   of one or two bin counters through the single-write bin memory.
// Last histogram pixel adds two peak sweeps over the bin memory, then a decision
//   step; no input is taken meanwhile.
// Reset (synchronous, active low) restores register defaults and clears bin valid
//   bits, black count, column and peak decision at once; no clearing pass.
`default_nettype none
module histogram_peak_binarizer import hpb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config writes go straight into the registers, always ready
    assign o_cfg_ready = 1'b1;

    // sequencer: accept, bin update, two sweeps, decide
    hpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in.kind),
        .i_last     (i_in.last),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // bin memory, sweep pipeline, thresholds, output register
    hpb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

@@ hdl/hpb_ctrl.sv @@
`default_nettype none
module hpb_ctrl import hpb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_kind,
    input  wire logic    i_last,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_HIST_A, S_HIST_B, S_SWEEP1, S_SWEEP2, S_FINAL
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_last     = r_last;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_kind) begin
                        o_cmd.accept_out = 1'b1;
                    end else begin
                        o_cmd.accept_hist = 1'b1;
                        n_last            = i_last;
                        n_state           = S_HIST_A;
                    end
                end
            end
            S_HIST_A: begin
                o_cmd.wr_a = 1'b1;
                if (i_status.two_bins) begin
                    n_state = S_HIST_B;
                end else if (r_last) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SWEEP1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HIST_B: begin
                o_cmd.wr_b = 1'b1;
                if (r_last) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SWEEP1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP1: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_done) begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.pass2       = 1'b1;
                    n_state           = S_SWEEP2;
                end
            end
            S_SWEEP2: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.pass2     = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.decide = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hpb_dp.sv @@
`default_nettype none
module hpb_dp import hpb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_cfg_valid,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out
);

    // configuration
    logic [NB_W-1:0]  r_bin_count;
    logic             r_keep;
    logic [DIM_W-1:0] r_width, r_height;
    logic [NB_W-1:0]  n_eff;
    logic [DIM_W-1:0] w_eff, h_eff, w_p3, pad;

    always_comb begin
        if (r_bin_count < NB_W'(3))             n_eff = NB_W'(3);
        else if (r_bin_count > NB_W'(MAX_BINS)) n_eff = NB_W'(MAX_BINS);
        else                                    n_eff = r_bin_count;
        if (r_width == '0)                      w_eff = DIM_W'(1);
        else if (r_width > DIM_W'(MAX_WIDTH))   w_eff = DIM_W'(MAX_WIDTH);
        else                                    w_eff = r_width;
        if (r_height == '0)                     h_eff = DIM_W'(1);
        else if (r_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
        else                                    h_eff = r_height;
        w_p3 = w_eff + DIM_W'(3);
        pad  = w_p3 & ~DIM_W'(3);
    end

    // pixel products
    logic [15:0] pn, pn_hi, pp1n;
    logic [8:0]  pix1;
    logic [7:0]  lo_t, hi_t, lo_c, hi_c, lo_m1, hi_m1;
    logic [BIN_W-1:0] bin_a;

    always_comb begin
        pix1  = {1'b0, i_in.pixel} + 9'd1;
        pn    = 16'(i_in.pixel) * 16'(n_eff);
        pp1n  = 16'(pix1) * 16'(n_eff);
        pn_hi = pn + 16'(n_eff);
        lo_t  = ceil_div255(pn);
        hi_t  = ceil_div255(pn_hi);
        lo_c  = (lo_t == 8'd0) ? 8'd1 : lo_t;
        hi_c  = (hi_t > 8'(n_eff)) ? 8'(n_eff) : hi_t;
        lo_m1 = lo_c - 8'd1;
        hi_m1 = hi_c - 8'd1;
        bin_a = lo_m1[BIN_W-1:0];
    end

    // bin count memory, valid bit per entry
    logic [CNT_W-1:0]    r_mem [MAX_BINS];
    logic [CNT_W-1:0]    r_mem_q, rd_data, wdata;
    logic [MAX_BINS-1:0] r_vld;
    logic                r_rd_vld;
    logic [BIN_W-1:0]    raddr, waddr, r_a, r_b;
    logic                r_two, we;
    logic [NB_W-1:0]     r_sw_idx;

    always_comb begin
        if (i_cmd.sweep_run) raddr = r_sw_idx[BIN_W-1:0];
        else if (i_cmd.wr_a) raddr = r_b;
        else                 raddr = bin_a;
        waddr   = i_cmd.wr_b ? r_b : r_a;
        we      = i_cmd.wr_a | i_cmd.wr_b;
        rd_data = r_rd_vld ? r_mem_q : '0;
        wdata   = rd_data + CNT_W'(rd_data != CNT_SAT);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_mem_q <= r_mem[raddr];
        if (i_cmd.accept_hist) begin
            r_a   <= bin_a;
            r_b   <= hi_m1[BIN_W-1:0];
            r_two <= (hi_c != lo_c);
        end
    end

    // peak sweep pipeline: read -> 3-bin sum -> compare
    logic                r_p1_v, r_sum_v;
    logic [NB_W-1:0]     r_p1_idx;
    logic [CNT_W-1:0]    r_w0, r_w1;
    logic [SUM_W-1:0]    r_sum, r_best;
    logic [BIN_W-1:0]    r_sum_ctr, r_first, r_second, peak_gap;
    logic [NB_W-1:0]     ctr_m1;

    always_comb begin
        peak_gap = (r_sum_ctr > r_first) ? r_sum_ctr - r_first : r_first - r_sum_ctr;
        ctr_m1   = r_p1_idx - NB_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_v) begin
            r_w0      <= rd_data;
            r_w1      <= r_w0;
            r_sum     <= SUM_W'(r_w1) + SUM_W'(r_w0) + SUM_W'(rd_data);
            r_sum_ctr <= ctr_m1[BIN_W-1:0];
        end
    end

    // decision, accumulators
    logic [BLACK_W-1:0] r_black;
    logic [COL_W-1:0]   r_col;
    logic [1:0]         r_mod3;
    logic [DIM_W-1:0]   col_next;
    logic [PROD_W-1:0]  r_prod, six_b;
    logic [BIN_W-1:0]   r_sel;
    logic               r_fallback, r_inv;

    always_comb begin
        col_next = {1'b0, r_col} + DIM_W'(1);
        six_b    = (PROD_W'(r_black) << 2) + (PROD_W'(r_black) << 1);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(pad) * PROD_W'(h_eff);
    end

    // output pass compare
    logic [6:0]  sel_p2;
    logic [5:0]  sel_m1;
    logic [15:0] lo_lim, hi_lim;
    logic        in_range;
    logic [7:0]  v;

    always_comb begin
        sel_p2   = {1'b0, r_sel} + 7'd2;
        sel_m1   = r_sel - 6'd1;
        lo_lim   = 16'd255 * 16'(sel_m1);
        hi_lim   = 16'd255 * 16'(sel_p2);
        in_range = ((r_sel == '0) || (lo_lim < pp1n)) && (pn <= hi_lim);
        if (r_fallback) begin
            v = ((i_in.pixel > FIXED_THRESHOLD) ? PIX_WHITE : PIX_BLACK) ^ {8{r_inv}};
        end else if (r_keep) begin
            v = in_range ? PIX_WHITE : PIX_BLACK;
        end else begin
            v = in_range ? PIX_BLACK : PIX_WHITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_out) begin
            o_out.out_pixel     <= v;
            o_out.used_fallback <= r_fallback;
            o_out.out_last      <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= NB_W'(16);
            r_keep      <= 1'b1;
            r_width     <= DIM_W'(640);
            r_height    <= DIM_W'(480);
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_sw_idx    <= '0;
            r_p1_v      <= 1'b0;
            r_p1_idx    <= '0;
            r_sum_v     <= 1'b0;
            r_best      <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_black     <= '0;
            r_col       <= '0;
            r_mod3      <= '0;
            r_sel       <= '0;
            r_fallback  <= 1'b0;
            r_inv       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BIN_COUNT:    r_bin_count <= i_cfg_data[NB_W-1:0];
                    CFG_KEEP_LARGEST: r_keep      <= i_cfg_data[0];
                    CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data;
                    default: ;
                endcase
            end

            r_rd_vld <= r_vld[raddr];
            if (i_cmd.decide) begin
                r_vld <= '0;
            end else if (we) begin
                r_vld[waddr] <= 1'b1;
            end

            // sweep issue and sum valid
            r_p1_v   <= i_cmd.sweep_run && (r_sw_idx < n_eff);
            r_p1_idx <= r_sw_idx;
            r_sum_v  <= r_p1_v && (r_p1_idx >= NB_W'(2));
            if (i_cmd.sweep_start) begin
                r_sw_idx <= '0;
                r_best   <= '0;
                if (i_cmd.pass2) r_second <= '0;
                else             r_first  <= '0;
            end else begin
                if (i_cmd.sweep_run && (r_sw_idx < n_eff)) begin
                    r_sw_idx <= r_sw_idx + NB_W'(1);
                end
                if (r_sum_v && (r_best < r_sum)) begin
                    if (!i_cmd.pass2) begin
                        r_best  <= r_sum;
                        r_first <= r_sum_ctr;
                    end else if (peak_gap > BIN_W'(2)) begin
                        r_best   <= r_sum;
                        r_second <= r_sum_ctr;
                    end
                end
            end

            // black count over every third column
            if (i_cmd.accept_hist) begin
                if ((r_mod3 == 2'd0) && (i_in.pixel <= FIXED_THRESHOLD)
                        && (r_black != BLACK_SAT)) begin
                    r_black <= r_black + BLACK_W'(1);
                end
                if (col_next >= w_eff) begin
                    r_col  <= '0;
                    r_mod3 <= '0;
                end else begin
                    r_col  <= col_next[COL_W-1:0];
                    r_mod3 <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                end
            end

            if (i_cmd.decide) begin
                if (r_second == '0) begin
                    r_fallback <= 1'b1;
                    r_inv      <= (r_prod < six_b);
                    r_sel      <= '0;
                end else begin
                    r_fallback <= 1'b0;
                    r_inv      <= 1'b0;
                    r_sel      <= r_keep ? r_first : r_second;
                end
                r_black <= '0;
                r_col   <= '0;
                r_mod3  <= '0;
            end

            if (i_cmd.accept_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.out_free   = !o_out_valid || i_out_ready;
        o_status.two_bins   = r_two;
        o_status.sweep_done = (r_sw_idx == n_eff) && !r_p1_v && !r_sum_v;
    end

endmodule
`default_nettype wire

@@ hdl/hpb_checker.sv @@
`default_nettype none
module hpb_checker import hpb_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out
);

    a_pix_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.out_pixel == PIX_WHITE || o_out.out_pixel == PIX_BLACK))
        else $error("output pixel not binary");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_in.kind))
        else $error("result without output-pass transfer");

    a_hist_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in.kind) |=> !o_in_ready)
        else $error("ready during bin update");

endmodule

bind histogram_peak_binarizer hpb_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

@@ verif/histogram_peak_binarizer_tb.sv @@
`default_nettype none
module histogram_peak_binarizer_tb;
    import hpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_CYCLES = 300;   // covers two peak sweeps plus decision
    localparam int NUM_ITEMS    = 2000;
    localparam int NUM_PHASES   = 9;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_item         in_item = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    histogram_peak_binarizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pixels waiting to be sent, and binarized pixels the block still owes us
    t_in_item  pixel_queue[$];
    t_out_item binarized_queue[$];
    int        errors = 0;
    int        items_made = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Shadow of the block: registers as written, plus histogram state
    int unsigned sh_bins = 16, sh_keep = 1, sh_width = 640, sh_height = 480;
    int unsigned hist[MAX_BINS];
    int unsigned black_tally = 0, col_pos = 0, peak_bin = 0;
    bit          fixed_mode = 0, invert_mode = 0;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Pick the peak bin (or the fixed threshold) at the end of a histogram pass
    task automatic choose_peak();
        int unsigned n, a, s, d, best, first, second;
        longint unsigned total;
        n = clamp(sh_bins, 3, MAX_BINS);
        first = 0;
        second = 0;
        best = 0;
        for (a = 1; a + 1 < n; a++) begin
            s = hist[a-1] + hist[a] + hist[a+1];
            if (best < s) begin
                best = s;
                first = a;
            end
        end
        best = 0;
        for (a = 1; a + 1 < n; a++) begin
            s = hist[a-1] + hist[a] + hist[a+1];
            d = (a > first) ? a - first : first - a;
            if (best < s && d > 2) begin
                best = s;
                second = a;
            end
        end
        if (second == 0) begin
            fixed_mode = 1;
            total = longint'((clamp(sh_width, 1, MAX_WIDTH) + 3) & ~32'd3)
                    * clamp(sh_height, 1, MAX_HEIGHT) / 3;
            invert_mode = (total < 2 * longint'(black_tally));
            peak_bin = 0;
        end else begin
            fixed_mode = 0;
            invert_mode = 0;
            peak_bin = (sh_keep == 1) ? first : second;
        end
        foreach (hist[i]) hist[i] = 0;
        black_tally = 0;
        col_pos = 0;
    endtask

    // Update the shadow state for one accepted pixel, queue its expected output
    task automatic binarize_pixel(t_in_item it);
        int unsigned n, t, lo, hi, pix, v;
        t_out_item   o;
        n = clamp(sh_bins, 3, MAX_BINS);
        pix = it.pixel;
        if (!it.kind) begin
            for (t = 1; t <= n; t++) begin
                lo = 255 * (t - 1) / n;
                hi = 255 * t / n;
                if (lo <= pix && pix <= hi && hist[t-1] < CNT_SAT) hist[t-1]++;
            end
            if (col_pos % 3 == 0 && pix <= FIXED_THRESHOLD && black_tally < BLACK_SAT)
                black_tally++;
            col_pos = (col_pos + 1 >= clamp(sh_width, 1, MAX_WIDTH)) ? 0 : col_pos + 1;
            if (it.last) choose_peak();
        end else begin
            if (fixed_mode) begin
                v = (pix > FIXED_THRESHOLD) ? 255 : 0;
                if (invert_mode) v = v ^ 255;
            end else begin
                lo = (peak_bin == 0) ? 0 : 255 * (peak_bin - 1) / n;
                hi = 255 * (peak_bin + 2) / n;
                if (sh_keep == 1) v = (lo <= pix && pix <= hi) ? 255 : 0;
                else v = (lo <= pix && pix <= hi) ? 0 : 255;
            end
            o.out_pixel = v[7:0];
            o.used_fallback = fixed_mode;
            o.out_last = it.last;
            binarized_queue.push_back(o);
        end
    endtask

    // Driver: a new pixel goes out only once the previous transfer completed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) binarize_pixel(in_item);
            if (!in_valid || in_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item <= pixel_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (binarized_queue.size() == 0) begin
                    report_mismatch("unexpected output", out_item.out_pixel, -1);
                end else begin
                    want = binarized_queue.pop_front();
                    if (out_item.out_pixel !== want.out_pixel)
                        report_mismatch("out_pixel", out_item.out_pixel, want.out_pixel);
                    if (out_item.used_fallback !== want.used_fallback)
                        report_mismatch("used_fallback", out_item.used_fallback,
                                        want.used_fallback);
                    if (out_item.out_last !== want.out_last)
                        report_mismatch("out_last", out_item.out_last, want.out_last);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_pixel(bit kind, int pix, bit last);
        t_in_item it;
        it.kind = kind;
        it.pixel = pix[7:0];
        it.last = last;
        pixel_queue.push_back(it);
        items_made++;
    endtask

    // One register write; the caller drops cfg_valid after the last one
    task automatic cfg_write(t_cfg_idx idx, int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[DIM_W-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_BIN_COUNT:    sh_bins = data & 32'h7F;
            CFG_KEEP_LARGEST: sh_keep = data & 32'h1;
            CFG_IMAGE_WIDTH:  sh_width = data & 32'h1FFF;
            CFG_IMAGE_HEIGHT: sh_height = data & 32'h1FFF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || in_valid || binarized_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One image: histogram pass then output pass, random content
    task automatic random_image();
        int len, c1, c2, sp, pix, style, k;
        style = $urandom_range(3);
        c1 = $urandom_range(255);
        c2 = $urandom_range(255);
        sp = $urandom_range(1, 20);
        len = $urandom_range(1, 40);
        for (k = 0; k < len; k++) begin
            case (style)
                0: pix = $urandom_range(255);
                1: pix = c1 + $urandom_range(2 * sp) - sp;
                default: pix = (($urandom_range(1)) ? c1 : c2) + $urandom_range(2 * sp) - sp;
            endcase
            pix = (pix < 0) ? 0 : ((pix > 255) ? 255 : pix);
            // a stray output pixel in the middle of a histogram pass now and then
            if ($urandom_range(49) == 0) push_pixel(1'b1, $urandom_range(255), 1'b0);
            push_pixel(1'b0, pix, k == len - 1);
        end
        len = $urandom_range(1, 25);
        for (k = 0; k < len; k++)
            push_pixel(1'b1, $urandom_range(255), k == len - 1);
    endtask

    initial begin
        int p;
        int unsigned nb, kp, w, h;
        foreach (hist[i]) hist[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: output pass before any decision (selected bin zero)
        send_idle_pct = 37;
        recv_idle_pct = 84;
        push_pixel(1'b1, 0, 1'b0);
        push_pixel(1'b1, 255, 1'b0);
        push_pixel(1'b1, 140, 1'b0);
        push_pixel(1'b1, 141, 1'b1);
        // histogram pass with bin boundaries, extremes and the threshold
        push_pixel(1'b0, 0, 1'b0);
        push_pixel(1'b0, 255, 1'b0);
        push_pixel(1'b0, 15, 1'b0);
        push_pixel(1'b0, 16, 1'b0);
        push_pixel(1'b0, 17, 1'b0);
        push_pixel(1'b0, 140, 1'b0);
        push_pixel(1'b0, 141, 1'b0);
        push_pixel(1'b0, 127, 1'b0);
        push_pixel(1'b0, 128, 1'b1);
        push_pixel(1'b1, 0, 1'b0);
        push_pixel(1'b1, 255, 1'b0);
        push_pixel(1'b1, 15, 1'b0);
        push_pixel(1'b1, 16, 1'b0);
        push_pixel(1'b1, 140, 1'b0);
        push_pixel(1'b1, 141, 1'b0);
        push_pixel(1'b1, 200, 1'b1);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            // extremes and out-of-range values first, then small random images
            case (p)
                0: begin nb = 3;   w = 1;    h = 1;    end
                1: begin nb = 64;  w = 4096; h = 4096; end
                2: begin nb = 0;   w = 0;    h = 0;    end
                3: begin nb = 127; w = 8191; h = 8191; end
                default: begin
                    nb = $urandom_range(3, 64);
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 6);
                end
            endcase
            kp = (p < 4) ? p % 2 : $urandom_range(1);
            cfg_write(CFG_BIN_COUNT, nb);
            cfg_write(CFG_KEEP_LARGEST, kp);
            cfg_write(CFG_IMAGE_WIDTH, w);
            cfg_write(CFG_IMAGE_HEIGHT, h);
            cfg_valid <= 1'b0;
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 84;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (items_made < (p + 1) * NUM_ITEMS / NUM_PHASES) random_image();
        end

        wait_drained();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/hpb_pkg.sv
hdl/hpb_ctrl.sv
hdl/hpb_dp.sv
hdl/histogram_peak_binarizer.sv
hdl/hpb_checker.sv
verif/histogram_peak_binarizer_tb.sv
